// File: sv/cis_pkg.sv
// shared constants, codes and types of the counted id set table
`default_nettype none
package cis_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_BITS = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_BITS-1:0] t_idx;
    typedef logic [LEN_BITS-1:0] t_len;

    typedef enum logic [2:0] {
        FN_ADD     = 3'd0,
        FN_REMOVE  = 3'd1,
        FN_INC     = 3'd2,
        FN_DEC     = 3'd3,
        FN_DEC_ALL = 3'd4,
        FN_DEC_MAX = 3'd5,
        FN_INDEX   = 3'd6,
        FN_GET     = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BEYOND    = 2'd3
    } t_status;

    typedef struct packed {
        t_key        id;
        logic [31:0] cnt;
    } t_entry;

endpackage
`default_nettype wire

// File: sv/cis_if.sv
// request and response channel interfaces
`default_nettype none
interface cis_req_if import cis_pkg::*; ();
    logic        valid;
    logic        ready;
    t_func       func;
    logic [31:0] key;
    logic [5:0]  position;

    modport source (output valid, output func, output key, output position, input ready);
    modport sink (input valid, input func, input key, input position, output ready);
endinterface

interface cis_rsp_if import cis_pkg::*; ();
    logic        valid;
    logic        ready;
    t_status     status;
    logic        flag;
    logic [5:0]  found_index;
    logic [31:0] item_value;
    logic [31:0] count_value;
    logic [6:0]  set_length;
    logic [31:0] max_count;

    modport source (
        output valid, output status, output flag, output found_index,
        output item_value, output count_value, output set_length, output max_count,
        input ready
    );
    modport sink (
        input valid, input status, input flag, input found_index,
        input item_value, input count_value, input set_length, input max_count,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/cis_ram.sv
// simple dual-port ram with registered read
`default_nettype none
module cis_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/counted_id_set_table.sv
// counted id set table: sequencer over one entry ram
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    func, key, position
//   o_rsp    out  valid/ready    status, flag, found_index, item_value,
//                                count_value, set_length, max_count
//
// one beat in, one beat out; a new request is taken only when the sequencer is idle
// key lookups scan the entries in order, a removal then moves the last entry into its slot
// dec_all walks down from the last entry, decrementing kept entries and removing the rest
// get_item reads one entry; lookups use the single ram read port, one entry per cycle
// reset clears length, peak and response valid; the ram needs no clearing
// a stalled response holds the sequencer in its final state until taken
`default_nettype none
module counted_id_set_table import cis_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cis_req_if.sink   i_req,
    cis_rsp_if.source o_rsp
);

    localparam t_len LEN_ONE = t_len'(1);
    localparam t_len LEN_CAP = t_len'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_LAST,
        S_MOVE,
        S_GET_RD,
        S_GET,
        S_DA_RD,
        S_DA_CHK,
        S_FIN
    } t_state;

    t_state      r_state;
    t_func       r_func;
    t_key        r_key;
    logic [5:0]  r_pos;
    t_len        r_ptr;
    logic        r_chk_v;
    t_idx        r_chk_idx;
    logic        r_found;
    t_idx        r_idx;
    t_entry      r_ent;
    t_len        r_total;
    logic [31:0] r_peak;

    t_status     r_status;
    logic        r_flag;
    logic [5:0]  r_fidx;
    logic [31:0] r_item;
    logic [31:0] r_cnt;

    logic        r_o_valid;
    t_status     r_o_status;
    logic        r_o_flag;
    logic [5:0]  r_o_fidx;
    logic [31:0] r_o_item;
    logic [31:0] r_o_cnt;
    logic [6:0]  r_o_len;
    logic [31:0] r_o_max;

    logic        ram_we;
    t_idx        ram_wa;
    t_entry      ram_wd;
    t_idx        ram_ra;
    t_entry      ram_q;
    t_len        last_ptr;
    logic [31:0] inc_cnt;
    logic [31:0] dec_cnt;
    logic        can_add;

    cis_ram #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_q)
    );

    assign last_ptr = r_total - LEN_ONE;
    assign inc_cnt  = (&r_ent.cnt) ? r_ent.cnt : r_ent.cnt + 32'd1;
    assign dec_cnt  = (r_ent.cnt != 32'd0) ? r_ent.cnt - 32'd1 : r_ent.cnt;
    assign can_add  = (r_total < LEN_CAP);

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_idx;
        ram_wd = r_ent;
        ram_ra = r_ptr[IDX_BITS-1:0];
        unique case (r_state)
            S_ACT: begin
                if (r_found) begin
                    if (r_func == FN_INC) begin
                        ram_we = 1'b1;
                        ram_wd = '{id: r_ent.id, cnt: inc_cnt};
                    end else if (r_func == FN_DEC) begin
                        ram_we = 1'b1;
                        ram_wd = '{id: r_ent.id, cnt: dec_cnt};
                    end
                end else if ((r_func == FN_ADD || r_func == FN_INC) && can_add) begin
                    ram_we = 1'b1;
                    ram_wa = r_total[IDX_BITS-1:0];
                    ram_wd = '{id: r_key, cnt: 32'd1};
                end
            end
            S_LAST: begin
                ram_ra = last_ptr[IDX_BITS-1:0];
            end
            S_MOVE: begin
                ram_we = 1'b1;
                ram_wd = ram_q;
            end
            S_DA_CHK: begin
                ram_we = (ram_q.cnt > 32'd1);
                ram_wa = r_ptr[IDX_BITS-1:0];
                ram_wd = '{id: ram_q.id, cnt: ram_q.cnt - 32'd1};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_peak    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_rsp.ready && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func   <= i_req.func;
                        r_key    <= t_key'(i_req.key);
                        r_pos    <= i_req.position;
                        r_fidx   <= '0;
                        r_cnt    <= '0;
                        r_chk_v  <= 1'b0;
                        unique case (i_req.func) inside
                            FN_ADD, FN_REMOVE, FN_INC, FN_DEC, FN_INDEX: begin
                                r_status <= ST_OK;
                                r_flag   <= 1'b0;
                                r_item   <= 32'(t_key'(i_req.key));
                                r_ptr    <= '0;
                                r_state  <= S_SCAN;
                            end
                            FN_DEC_ALL: begin
                                r_status <= ST_OK;
                                r_flag   <= 1'b0;
                                r_item   <= '0;
                                r_ptr    <= last_ptr;
                                if (r_total != '0) begin
                                    r_state <= S_DA_RD;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            FN_DEC_MAX: begin
                                r_status <= ST_OK;
                                r_item   <= '0;
                                if (r_peak != 32'd0) begin
                                    r_peak <= r_peak - 32'd1;
                                end
                                r_flag  <= (r_peak <= 32'd1);
                                r_state <= S_FIN;
                            end
                            FN_GET: begin
                                r_flag <= 1'b0;
                                r_item <= 32'(t_key'(i_req.key));
                                r_ptr  <= t_len'(i_req.position);
                                if (32'(i_req.position) < 32'(r_total)) begin
                                    r_status <= ST_OK;
                                    r_state  <= S_GET_RD;
                                end else begin
                                    r_status <= ST_BEYOND;
                                    r_state  <= S_FIN;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_flag   <= 1'b0;
                                r_item   <= 32'(t_key'(i_req.key));
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_chk_v && ram_q.id == r_key) begin
                        r_found <= 1'b1;
                        r_idx   <= r_chk_idx;
                        r_ent   <= ram_q;
                        r_state <= S_ACT;
                    end else if (r_ptr < r_total) begin
                        r_chk_v   <= 1'b1;
                        r_chk_idx <= r_ptr[IDX_BITS-1:0];
                        r_ptr     <= r_ptr + LEN_ONE;
                    end else if (!r_chk_v) begin
                        r_found <= 1'b0;
                        r_state <= S_ACT;
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                end
                S_ACT: begin
                    r_state <= (r_func == FN_REMOVE && r_found) ? S_LAST : S_FIN;
                    unique case (r_func) inside
                        FN_ADD, FN_INC: begin
                            if (r_found) begin
                                r_fidx <= 6'(r_idx);
                                if (r_func == FN_INC) begin
                                    r_cnt <= inc_cnt;
                                    if (inc_cnt > r_peak) begin
                                        r_peak <= inc_cnt;
                                        r_flag <= 1'b1;
                                    end
                                end else begin
                                    r_cnt <= r_ent.cnt;
                                end
                            end else if (!can_add) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_fidx  <= 6'(r_total[IDX_BITS-1:0]);
                                r_cnt   <= 32'd1;
                                r_total <= r_total + LEN_ONE;
                                if (r_func == FN_ADD) begin
                                    r_flag <= 1'b1;
                                end else if (r_peak == 32'd0) begin
                                    r_peak <= 32'd1;
                                end
                            end
                        end
                        FN_REMOVE: begin
                            if (r_found) begin
                                r_fidx  <= 6'(r_idx);
                                r_cnt   <= r_ent.cnt;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        FN_DEC: begin
                            if (r_found) begin
                                r_fidx <= 6'(r_idx);
                                r_cnt  <= dec_cnt;
                                r_flag <= (dec_cnt == 32'd0);
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (r_found) begin
                                r_fidx <= 6'(r_idx);
                                r_cnt  <= r_ent.cnt;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
                S_LAST: begin
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    r_total <= last_ptr;
                    if (r_func == FN_DEC_ALL && r_ptr != '0) begin
                        r_ptr   <= r_ptr - LEN_ONE;
                        r_state <= S_DA_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_GET_RD: begin
                    r_state <= S_GET;
                end
                S_GET: begin
                    r_fidx  <= r_pos;
                    r_item  <= 32'(ram_q.id);
                    r_cnt   <= ram_q.cnt;
                    r_state <= S_FIN;
                end
                S_DA_RD: begin
                    r_state <= S_DA_CHK;
                end
                S_DA_CHK: begin
                    if (ram_q.cnt <= 32'd1) begin
                        r_flag  <= 1'b1;
                        r_idx   <= r_ptr[IDX_BITS-1:0];
                        r_state <= S_LAST;
                    end else if (r_ptr != '0) begin
                        r_ptr   <= r_ptr - LEN_ONE;
                        r_state <= S_DA_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_flag   <= r_flag;
                        r_o_fidx   <= r_fidx;
                        r_o_item   <= r_item;
                        r_o_cnt    <= r_cnt;
                        r_o_len    <= 7'(r_total);
                        r_o_max    <= r_peak;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.flag        = r_o_flag;
    assign o_rsp.found_index = r_o_fidx;
    assign o_rsp.item_value  = r_o_item;
    assign o_rsp.count_value = r_o_cnt;
    assign o_rsp.set_length  = r_o_len;
    assign o_rsp.max_count   = r_o_max;

endmodule
`default_nettype wire

// File: bench/tb.sv
// self-checking testbench of the counted id set table with its own table predictor
`default_nettype none
module tb;
    import cis_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 72;

    typedef struct packed {
        t_status     status;
        logic        flag;
        logic [5:0]  found_index;
        logic [31:0] item_value;
        logic [31:0] count_value;
        logic [6:0]  set_length;
        logic [31:0] max_count;
    } table_answer_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cis_req_if req_ch ();
    cis_rsp_if rsp_ch ();

    counted_id_set_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #4 i_clk = ~i_clk;

    // predicted table contents
    logic [31:0] tbl_ids [CAPACITY];
    logic [31:0] tbl_cnts [CAPACITY];
    int          tbl_fill;
    logic [31:0] tbl_peak;

    table_answer_t expected_answers [$];
    logic [31:0]   key_pool [POOL_SIZE];
    int            mismatches;
    int            quiet_cycles;
    bit            calm;
    bit            hold_request;
    int            hold_left;

    function automatic int find_id(logic [31:0] k);
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_ids[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void drop_entry(int i);
        tbl_fill--;
        tbl_ids[i]  = tbl_ids[tbl_fill];
        tbl_cnts[i] = tbl_cnts[tbl_fill];
    endfunction

    function automatic table_answer_t table_apply(t_func f, logic [31:0] k, logic [5:0] p);
        table_answer_t a;
        int hit;
        a = '0;
        a.status = ST_OK;
        a.item_value = k;
        case (f)
            FN_ADD, FN_INC: begin
                hit = find_id(k);
                if (hit >= 0) begin
                    a.found_index = hit[5:0];
                    if (f == FN_INC) begin
                        if (tbl_cnts[hit] != 32'hFFFF_FFFF) tbl_cnts[hit]++;
                        if (tbl_cnts[hit] > tbl_peak) begin
                            tbl_peak = tbl_cnts[hit];
                            a.flag = 1'b1;
                        end
                    end
                    a.count_value = tbl_cnts[hit];
                end else if (tbl_fill >= CAPACITY) begin
                    a.status = ST_FULL;
                end else begin
                    tbl_ids[tbl_fill]  = k;
                    tbl_cnts[tbl_fill] = 32'd1;
                    a.found_index = tbl_fill[5:0];
                    tbl_fill++;
                    a.count_value = 32'd1;
                    if (f == FN_ADD) a.flag = 1'b1;
                    else if (tbl_peak == 32'd0) tbl_peak = 32'd1;
                end
            end
            FN_REMOVE: begin
                hit = find_id(k);
                if (hit < 0) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    a.found_index = hit[5:0];
                    a.count_value = tbl_cnts[hit];
                    drop_entry(hit);
                end
            end
            FN_DEC: begin
                hit = find_id(k);
                if (hit < 0) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    a.found_index = hit[5:0];
                    if (tbl_cnts[hit] != 32'd0) tbl_cnts[hit]--;
                    a.count_value = tbl_cnts[hit];
                    a.flag = (tbl_cnts[hit] == 32'd0);
                end
            end
            FN_DEC_ALL: begin
                a.item_value = '0;
                // scan downward so the entry moved into a freed slot is already done
                for (int i = tbl_fill - 1; i >= 0; i--) begin
                    if (tbl_cnts[i] <= 32'd1) begin
                        drop_entry(i);
                        a.flag = 1'b1;
                    end else begin
                        tbl_cnts[i]--;
                    end
                end
            end
            FN_DEC_MAX: begin
                a.item_value = '0;
                if (tbl_peak != 32'd0) tbl_peak--;
                a.flag = (tbl_peak == 32'd0);
            end
            FN_INDEX: begin
                hit = find_id(k);
                if (hit < 0) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    a.found_index = hit[5:0];
                    a.count_value = tbl_cnts[hit];
                end
            end
            default: begin
                if (int'(p) < tbl_fill) begin
                    a.found_index = p;
                    a.item_value  = tbl_ids[p];
                    a.count_value = tbl_cnts[p];
                end else begin
                    a.status = ST_BEYOND;
                end
            end
        endcase
        a.set_length = tbl_fill[6:0];
        a.max_count  = tbl_peak;
        return a;
    endfunction

    task automatic send_op(t_func f, logic [31:0] k, logic [5:0] p);
        while (!calm && $urandom_range(99) < 22) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.key      <= k;
        req_ch.position <= p;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_answers.push_back(table_apply(f, k, p));
    endtask

    task automatic send_random_op(int span);
        int          pick;
        t_func       f;
        logic [31:0] k;
        logic [5:0]  p;
        pick = $urandom_range(99);
        if (pick < 30) f = FN_INC;
        else if (pick < 45) f = FN_ADD;
        else if (pick < 60) f = FN_DEC;
        else if (pick < 70) f = FN_REMOVE;
        else if (pick < 80) f = FN_INDEX;
        else if (pick < 90) f = FN_GET;
        else if (pick < 94) f = FN_DEC_ALL;
        else f = FN_DEC_MAX;
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
        if (tbl_fill > 0 && $urandom_range(99) < 70) p = 6'($urandom_range(tbl_fill - 1));
        else p = 6'($urandom_range(63));
        send_op(f, k, p);
    endtask

    task automatic wait_drained;
        req_ch.valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        send_op(FN_GET, 32'd5, 6'd0);
        send_op(FN_REMOVE, 32'd5, 6'($urandom_range(63)));
        send_op(FN_DEC, 32'd5, 6'($urandom_range(63)));
        send_op(FN_INDEX, 32'd5, 6'($urandom_range(63)));
        send_op(FN_DEC_MAX, $urandom, 6'($urandom_range(63)));
        send_op(FN_DEC_ALL, $urandom, 6'($urandom_range(63)));
        send_op(FN_ADD, 32'h0000_0000, 6'h3F);
        send_op(FN_ADD, 32'hFFFF_FFFF, 6'h00);
        send_op(FN_ADD, 32'h0000_0000, 6'h2A);
        send_op(FN_INC, 32'hFFFF_FFFF, 6'h15);
        send_op(FN_INC, 32'h0000_0000, 6'h00);
        send_op(FN_INC, 32'h1234_5678, 6'h3F);
        send_op(FN_INDEX, 32'h1234_5678, 6'h00);
        send_op(FN_GET, 32'hFFFF_FFFF, 6'd2);
        send_op(FN_GET, 32'h0000_0000, 6'd63);
        send_op(FN_GET, 32'hFFFF_FFFF, 6'd1);
        send_op(FN_DEC, 32'h1234_5678, 6'h3F);
        // count already at zero stays there
        send_op(FN_DEC, 32'h1234_5678, 6'h00);
        send_op(FN_REMOVE, 32'h0000_0000, 6'h3F);
        send_op(FN_GET, 32'd0, 6'd0);
        send_op(FN_DEC_ALL, 32'hFFFF_FFFF, 6'h3F);
        send_op(FN_DEC_MAX, 32'hFFFF_FFFF, 6'h00);
        send_op(FN_DEC_MAX, 32'h0000_0000, 6'h3F);
        send_op(FN_INC, 32'hFFFF_FFFF, 6'h00);
        send_op(FN_DEC_ALL, 32'd0, 6'h00);
        wait_drained();
    endtask

    task automatic test_full_table;
        while (tbl_fill < CAPACITY) begin
            if ($urandom_range(1) == 0) begin
                send_op(FN_ADD, $urandom, 6'($urandom_range(63)));
            end else begin
                send_op(FN_INC, $urandom, 6'($urandom_range(63)));
            end
        end
        send_op(FN_ADD, 32'hFFFF_FFFF, 6'd0);
        send_op(FN_INC, 32'h0000_0000, 6'd63);
        send_op(FN_ADD, $urandom, 6'($urandom_range(63)));
        send_op(FN_GET, $urandom, 6'd63);
        send_op(FN_GET, $urandom, 6'd0);
        send_op(FN_INDEX, tbl_ids[CAPACITY-1], 6'($urandom_range(63)));
        send_op(FN_INC, tbl_ids[5], 6'($urandom_range(63)));
        send_op(FN_REMOVE, tbl_ids[10], 6'($urandom_range(63)));
        send_op(FN_GET, $urandom, 6'd10);
        send_op(FN_INC, $urandom, 6'($urandom_range(63)));
        send_op(FN_DEC_ALL, $urandom, 6'($urandom_range(63)));
        send_op(FN_DEC_ALL, $urandom, 6'($urandom_range(63)));
        wait_drained();
    endtask

    task automatic test_no_idle_burst;
        calm = 1'b1;
        repeat (120) send_random_op(16);
        wait_drained();
        calm = 1'b0;
    endtask

    task automatic test_random_mix;
        for (int n = 0; n < 350; n++) begin
            send_random_op((n % 100 < 50) ? 12 : POOL_SIZE);
        end
        wait_drained();
    endtask

    task automatic test_output_hold;
        hold_request = 1'b1;
        repeat (20) send_random_op(16);
        wait_drained();
    endtask

    // response side: random ready with one long hold-off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    always @(posedge i_clk) begin
        table_answer_t got;
        table_answer_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status      = rsp_ch.status;
            got.flag        = rsp_ch.flag;
            got.found_index = rsp_ch.found_index;
            got.item_value  = rsp_ch.item_value;
            got.count_value = rsp_ch.count_value;
            got.set_length  = rsp_ch.set_length;
            got.max_count   = rsp_ch.max_count;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d flag %0d idx %0d item %h cnt %h len %0d max %h",
                             got.status, got.flag, got.found_index, got.item_value,
                             got.count_value, got.set_length, got.max_count);
            end else begin
                want = expected_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected status %0d flag %0d idx %0d item %h cnt %h len %0d max %h",
                                 want.status, want.flag, want.found_index, want.item_value,
                                 want.count_value, want.set_length, want.max_count);
                        $display("          actual   status %0d flag %0d idx %0d item %h cnt %h len %0d max %h",
                                 got.status, got.flag, got.found_index, got.item_value,
                                 got.count_value, got.set_length, got.max_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FN_ADD;
        req_ch.key      <= '0;
        req_ch.position <= '0;
        tbl_fill     = 0;
        tbl_peak     = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_no_idle_burst();
        test_random_mix();
        test_output_hold();

        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
sv/cis_pkg.sv
sv/cis_if.sv
sv/cis_ram.sv
sv/counted_id_set_table.sv
bench/tb.sv
